// ===== hw/rtl/ddap_pkg.sv =====
// Shared types and constants for the dotted-decimal address parser.
// No dependencies; imported by ddap_step, dotted_decimal_address_parser_core and ddap_checker.
`timescale 1ns / 1ps
`default_nettype none

package ddap_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 32;

  // Parser phase codes.
  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_SEEK  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [ByteW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [ByteW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] LAST_FIELD = 2'd3;

  typedef struct packed {
    logic [1:0]       phase;
    logic [1:0]       field_index;
    logic [AddrW-1:0] digit_value;
    logic [AddrW-1:0] address_so_far;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_SKIP,
    field_index:    2'd0,
    digit_value:    '0,
    address_so_far: '0
  };

endpackage

`default_nettype wire

// ===== hw/rtl/ddap_step.sv =====
// Next-state logic of the parser: one text byte against the current state.
// Depends on ddap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddap_step (
  input  wire ddap_pkg::parse_state_t     state,
  input  wire logic [ddap_pkg::ByteW-1:0] text_byte,
  output ddap_pkg::parse_state_t          state_next,
  output logic [ddap_pkg::AddrW-1:0]      address
);
  import ddap_pkg::*;

  logic             is_digit;
  logic             is_dot;
  logic [AddrW-1:0] digit_in;
  logic [AddrW-1:0] times_ten;
  logic [4:0]       shift;
  logic [AddrW-1:0] closed_addr;

  assign is_digit  = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
  assign is_dot    = (text_byte == CHAR_DOT);
  // For '0'..'9' the low nibble is the digit value.
  assign digit_in  = {{(AddrW-4){1'b0}}, text_byte[3:0]};
  assign times_ten = (state.digit_value << 3) + (state.digit_value << 1);
  // Field i sits at shift 24 - 8*i, which is 8 times the inverted index.
  assign shift       = {~state.field_index, 3'b000};
  assign closed_addr = state.address_so_far | (state.digit_value << shift);

  always_comb begin
    state_next = state;
    address    = (state.phase == PH_DIGIT) ? closed_addr : state.address_so_far;
    if (text_byte == CHAR_NUL) begin
      state_next = STATE_RESET;
    end else begin
      unique case (state.phase)
        PH_SKIP: begin
          if (is_digit) begin
            state_next.digit_value = digit_in;
            state_next.phase       = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            state_next.digit_value = times_ten + digit_in;
          end else begin
            state_next.address_so_far = closed_addr;
            state_next.digit_value    = '0;
            if (state.field_index == LAST_FIELD) begin
              state_next.phase = PH_DONE;
            end else if (is_dot) begin
              state_next.field_index = state.field_index + 2'd1;
              state_next.phase       = PH_SKIP;
            end else begin
              state_next.phase = PH_SEEK;
            end
          end
        end
        PH_SEEK: begin
          if (is_dot) begin
            state_next.field_index = state.field_index + 2'd1;
            state_next.phase       = PH_SKIP;
          end
        end
        PH_DONE: begin
          state_next = state;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dotted_decimal_address_parser_core.sv =====
// Streaming dotted-decimal address parser: input register, parser state,
// result register. Depends on ddap_pkg and ddap_step.
//
// Usage:
//   The slave channel (s_*) takes one text byte per beat. Bytes other than
//   zero update the parser state and produce nothing. A zero byte closes any
//   open field and produces one 32-bit address beat on the master channel
//   (m_*), first field in bits 31..24; the parser then starts a new string.
//   A zero byte passes two register stages (input register, result register)
//   before its address is presented on m_tdata. Throughput: one byte per
//   cycle while no zero byte waits on a stalled result; the per-byte work is
//   a multiply-by-ten add plus a shift-and-OR between the two registers.
//   Reset (rst, synchronous, active high) empties both registers and puts
//   the parser in its initial state.
//   When m_tready is low with a result waiting, non-zero bytes keep flowing;
//   a zero byte holds in the input register, and s_tready drops only once
//   that register is occupied and cannot move on.
`timescale 1ns / 1ps
`default_nettype none

module dotted_decimal_address_parser_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [ddap_pkg::ByteW-1:0]  s_tdata,   // [7:0] text_byte
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [ddap_pkg::AddrW-1:0]       m_tdata    // [31:0] address
);
  import ddap_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  parse_state_t     state;
  parse_state_t     state_next;
  logic [AddrW-1:0] address_next;
  logic             is_end;
  logic             advance;

  assign is_end   = (in_byte == CHAR_NUL);
  // Only the end-of-string byte needs room in the result register.
  assign advance  = in_valid && (!is_end || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  ddap_step u_step (
    .state      (state),
    .text_byte  (in_byte),
    .state_next (state_next),
    .address    (address_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_end) begin
      m_tdata <= address_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ddap_checker.sv =====
// Port-level checks for dotted_decimal_address_parser_core, and the bind
// that attaches them. Depends on ddap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddap_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic [ddap_pkg::ByteW-1:0] s_tdata,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [ddap_pkg::AddrW-1:0] m_tdata
);
  import ddap_pkg::*;

  // A stalled result beat holds its address.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // With room on the output side the input never blocks.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free output");

  // An end-of-string beat yields a result once the output frees.
  a_end_yields_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata == CHAR_NUL) ##1 (!m_tvalid || m_tready)
    |=> m_tvalid)
    else $error("end of string produced no result");

endmodule

bind dotted_decimal_address_parser_core ddap_checker u_ddap_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
